@@ rtl/ffa_pkg.sv @@
`timescale 1ns / 1ps
package ffa_pkg;

   // Sizes of the block table and of the data words.
   localparam int TABLE_ENTRIES = 64;
   localparam int WORD_W        = 32;
   localparam int GRAIN         = 4;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ILLEGAL   = 3'd1,
      ST_NO_ENTRY  = 3'd2,
      ST_NO_SPACE  = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   // Request actions; the last code is accepted and ignored.
   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_POOL_BASE = 1'b0,
      CSR_POOL_SIZE = 1'b1
   } csr_index_type;

   // One block table entry.
   typedef struct packed {
      logic              used;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] size;
   } entry_type;

   // Controller states.
   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_A_CHK, S_A_RD, S_A_EV, S_A_APP, S_A_HIT,
      S_SH_RD, S_SH_WR, S_SP_LO, S_SP_HI, S_F_RD, S_F_EV, S_F_HIT,
      S_F_TAIL, S_F_NX, S_GAP_RD, S_GAP_WR, S_F_PRV, S_F_PM, S_DONE
   } state_type;

   // Table read address source.
   typedef enum logic [2:0] {
      RA_IDX, RA_IDX_M1, RA_IDX_P1, RA_L_P1, RA_L_M1
   } rsel_type;

   // Table write address source.
   typedef enum logic [1:0] {
      WA_IDX, WA_L, WA_L_P1, WA_L_M1
   } wsel_type;

   // Table write data source.
   typedef enum logic [3:0] {
      WD_FIRST, WD_APPEND, WD_COPY, WD_SPLIT_LO, WD_SPLIT_HI,
      WD_WHOLE, WD_FREE, WD_NEXT_MERGE, WD_PREV_MERGE
   } wdat_type;

   // Scan index update.
   typedef enum logic [2:0] {
      IDX_HOLD, IDX_INC, IDX_DEC, IDX_COUNT, IDX_L, IDX_L_P1
   } idx_op_type;

   // Entry count update.
   typedef enum logic [2:0] {
      CNT_HOLD, CNT_ZERO, CNT_ONE, CNT_INC, CNT_DEC, CNT_L, CNT_L_M1
   } cnt_op_type;

   // Saved entry update.
   typedef enum logic [1:0] {
      CUR_HOLD, CUR_LOAD, CUR_ADD
   } cur_op_type;

   // Result address source.
   typedef enum logic [2:0] {
      ADDR_ZERO, ADDR_FIRST, ADDR_APPEND, ADDR_SPLIT, ADDR_WHOLE
   } addr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load;
      logic         rd_en;
      rsel_type     rsel;
      logic         wr_en;
      wsel_type     wsel;
      wdat_type     wdat;
      idx_op_type   idx_op;
      cnt_op_type   cnt_op;
      cur_op_type   cur_op;
      logic         l_load;
      logic         tp_sub;
      logic         res_wr;
      status_type   res_status;
      addr_sel_type addr_sel;
      logic         publish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      action_type action;
      logic       illegal;
      logic       count_zero;
      logic       count_full;
      logic       idx_eq_count;
      logic       fit;
      logic       split_ok;
      logic       space_bad;
      logic       shift_more;
      logic       tp_hit;
      logic       l_last;
      logic       l_zero;
      logic       rd_used;
      logic       gap_more;
      logic       out_free;
   } sts_type;

endpackage

@@ rtl/ffa_if.sv @@
`timescale 1ns / 1ps
// Request channel.
interface ffa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] req_size;
   logic [31:0] block_address;
   modport source (output valid, action, req_size, block_address, input ready);
   modport sink (input valid, action, req_size, block_address, output ready);
endinterface

// Response channel.
interface ffa_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] address;
   modport source (output valid, status, address, input ready);
   modport sink (input valid, status, address, output ready);
endinterface

// Register write channel.
interface ffa_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/ffa_datapath.sv @@
`timescale 1ns / 1ps
module ffa_datapath #(
   parameter int TABLE_ENTRIES = ffa_pkg::TABLE_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       req_action,
   input  logic [31:0]      req_size,
   input  logic [31:0]      req_block_address,
   input  logic             csr_fire,
   input  logic [0:0]       csr_index,
   input  logic [31:0]      csr_data,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_address,
   input  ffa_pkg::cmd_type cmd,
   output ffa_pkg::sts_type sts
);

   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);
   localparam logic [CW-1:0] ONE  = CW'(1);
   localparam logic [32:0] RND_ADD  = 33'(ffa_pkg::GRAIN - 1);
   localparam logic [32:0] RND_MASK = ~RND_ADD;

   ffa_pkg::entry_type mem [TABLE_ENTRIES];

   logic [31:0] pool_base_ff, pool_size_ff;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in, l_ff;
   logic [32:0] size_ff;
   logic [31:0] blk_ff, tp_ff, tp_next;
   ffa_pkg::action_type action_ff;
   ffa_pkg::entry_type rd_ff, cur_ff, cur_in, wd;
   ffa_pkg::status_type res_status_ff;
   logic [31:0] res_addr_ff, addr_calc;
   logic rsp_valid_ff;
   logic [2:0] rsp_status_ff;
   logic [31:0] rsp_address_ff;
   logic [31:0] top, size32;
   logic [32:0] end33;
   logic [CW-1:0] ra, wa;

   assign top     = pool_base_ff + pool_size_ff;
   assign size32  = size_ff[31:0];
   assign end33   = {1'b0, rd_ff.offset} + {1'b0, rd_ff.size};
   assign tp_next = tp_ff - rd_ff.size;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
         pool_size_ff <= '0;
      end else if (csr_fire) begin
         unique case (ffa_pkg::csr_index_type'(csr_index))
            ffa_pkg::CSR_POOL_BASE: pool_base_ff <= csr_data;
            ffa_pkg::CSR_POOL_SIZE: pool_size_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Table read and write addresses.
   always_comb begin
      unique case (cmd.rsel)
         ffa_pkg::RA_IDX:    ra = idx_ff;
         ffa_pkg::RA_IDX_M1: ra = idx_ff - ONE;
         ffa_pkg::RA_IDX_P1: ra = idx_ff + ONE;
         ffa_pkg::RA_L_P1:   ra = l_ff + ONE;
         ffa_pkg::RA_L_M1:   ra = l_ff - ONE;
         default:            ra = idx_ff;
      endcase
      unique case (cmd.wsel)
         ffa_pkg::WA_IDX:  wa = idx_ff;
         ffa_pkg::WA_L:    wa = l_ff;
         ffa_pkg::WA_L_P1: wa = l_ff + ONE;
         ffa_pkg::WA_L_M1: wa = l_ff - ONE;
         default:          wa = idx_ff;
      endcase
   end

   // Table write data.
   always_comb begin
      wd = rd_ff;
      unique case (cmd.wdat)
         ffa_pkg::WD_FIRST:      wd = '{1'b1, 32'd0, size32};
         ffa_pkg::WD_APPEND:     wd = '{1'b1, end33[31:0], size32};
         ffa_pkg::WD_COPY:       wd = rd_ff;
         ffa_pkg::WD_SPLIT_LO:   wd = '{1'b1, cur_ff.offset, size32};
         ffa_pkg::WD_SPLIT_HI:   wd = '{1'b0, cur_ff.offset + size32, cur_ff.size - size32};
         ffa_pkg::WD_WHOLE:      wd = '{1'b1, cur_ff.offset, cur_ff.size};
         ffa_pkg::WD_FREE:       wd = '{1'b0, cur_ff.offset, cur_ff.size};
         ffa_pkg::WD_NEXT_MERGE: wd = '{1'b0, cur_ff.offset, cur_ff.size + rd_ff.size};
         ffa_pkg::WD_PREV_MERGE: wd = '{rd_ff.used, rd_ff.offset, rd_ff.size + cur_ff.size};
         default:                wd = rd_ff;
      endcase
   end

   // Block table memory with a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wa[AW-1:0]] <= wd;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[ra[AW-1:0]];
      end
   end

   // Index, count and saved entry updates.
   always_comb begin
      idx_in = idx_ff;
      unique case (cmd.idx_op)
         ffa_pkg::IDX_HOLD:  idx_in = idx_ff;
         ffa_pkg::IDX_INC:   idx_in = idx_ff + ONE;
         ffa_pkg::IDX_DEC:   idx_in = idx_ff - ONE;
         ffa_pkg::IDX_COUNT: idx_in = count_ff;
         ffa_pkg::IDX_L:     idx_in = l_ff;
         ffa_pkg::IDX_L_P1:  idx_in = l_ff + ONE;
         default:            idx_in = idx_ff;
      endcase
      if (cmd.load) begin
         idx_in = '0;
      end
      count_in = count_ff;
      unique case (cmd.cnt_op)
         ffa_pkg::CNT_HOLD: count_in = count_ff;
         ffa_pkg::CNT_ZERO: count_in = '0;
         ffa_pkg::CNT_ONE:  count_in = ONE;
         ffa_pkg::CNT_INC:  count_in = count_ff + ONE;
         ffa_pkg::CNT_DEC:  count_in = count_ff - ONE;
         ffa_pkg::CNT_L:    count_in = l_ff;
         ffa_pkg::CNT_L_M1: count_in = l_ff - ONE;
         default:           count_in = count_ff;
      endcase
      unique case (cmd.cur_op)
         ffa_pkg::CUR_HOLD: cur_in = cur_ff;
         ffa_pkg::CUR_LOAD: cur_in = rd_ff;
         ffa_pkg::CUR_ADD:  cur_in = '{1'b0, cur_ff.offset, cur_ff.size + rd_ff.size};
         default:           cur_in = cur_ff;
      endcase
   end

   // Result address.
   always_comb begin
      unique case (cmd.addr_sel)
         ffa_pkg::ADDR_ZERO:   addr_calc = '0;
         ffa_pkg::ADDR_FIRST:  addr_calc = top - size32;
         ffa_pkg::ADDR_APPEND: addr_calc = top - end33[31:0] - size32;
         ffa_pkg::ADDR_SPLIT:  addr_calc = top - cur_ff.offset - size32;
         ffa_pkg::ADDR_WHOLE:  addr_calc = top - cur_ff.offset - cur_ff.size;
         default:              addr_calc = '0;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      cur_ff <= cur_in;
      if (cmd.load) begin
         action_ff <= ffa_pkg::action_type'(req_action);
         size_ff   <= ({1'b0, req_size} + RND_ADD) & RND_MASK;
         blk_ff    <= req_block_address;
         tp_ff     <= top;
      end else if (cmd.tp_sub) begin
         tp_ff <= tp_next;
      end
      if (cmd.l_load) begin
         l_ff <= idx_ff;
      end
      if (cmd.res_wr) begin
         res_status_ff <= cmd.res_status;
         res_addr_ff   <= addr_calc;
      end
      if (cmd.publish) begin
         rsp_status_ff  <= res_status_ff;
         rsp_address_ff <= res_addr_ff;
      end
   end

   // Status back to the controller.
   always_comb begin
      sts.action       = action_ff;
      sts.illegal      = (size_ff == '0) || (size_ff > {1'b0, pool_size_ff});
      sts.count_zero   = (count_ff == '0);
      sts.count_full   = (count_ff == FULL);
      sts.idx_eq_count = (idx_ff == count_ff);
      sts.fit          = !rd_ff.used && (rd_ff.size >= size32);
      sts.split_ok     = (size32 < cur_ff.size) && (count_ff != FULL);
      sts.space_bad    = (end33 > {1'b0, pool_size_ff})
                         || (({1'b0, pool_size_ff} - end33) < {1'b0, size32});
      sts.shift_more   = (idx_ff > l_ff + ONE);
      sts.tp_hit       = (tp_next == blk_ff);
      sts.l_last       = (l_ff + ONE == count_ff);
      sts.l_zero       = (l_ff == '0);
      sts.rd_used      = rd_ff.used;
      sts.gap_more     = (idx_ff + ONE < count_ff);
      sts.out_free     = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_address = rsp_address_ff;

endmodule

@@ rtl/ffa_ctrl.sv @@
`timescale 1ns / 1ps
module ffa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ffa_pkg::sts_type sts,
   output ffa_pkg::cmd_type cmd
);

   ffa_pkg::state_type state_ff, state_in;
   logic second_ff, second_in;

   // Next state.
   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      unique case (state_ff)
         ffa_pkg::S_IDLE: begin
            second_in = 1'b0;
            if (req_valid) state_in = ffa_pkg::S_DISPATCH;
         end
         ffa_pkg::S_DISPATCH: begin
            unique case (sts.action)
               ffa_pkg::ACT_ALLOC: state_in = ffa_pkg::S_A_CHK;
               ffa_pkg::ACT_FREE:  state_in = ffa_pkg::S_F_RD;
               default:            state_in = ffa_pkg::S_DONE;
            endcase
         end
         ffa_pkg::S_A_CHK: begin
            if (sts.illegal || sts.count_zero) state_in = ffa_pkg::S_DONE;
            else state_in = ffa_pkg::S_A_RD;
         end
         ffa_pkg::S_A_RD: begin
            if (!sts.idx_eq_count) state_in = ffa_pkg::S_A_EV;
            else if (sts.count_full) state_in = ffa_pkg::S_DONE;
            else state_in = ffa_pkg::S_A_APP;
         end
         ffa_pkg::S_A_EV: begin
            state_in = sts.fit ? ffa_pkg::S_A_HIT : ffa_pkg::S_A_RD;
         end
         ffa_pkg::S_A_APP: state_in = ffa_pkg::S_DONE;
         ffa_pkg::S_A_HIT: begin
            state_in = sts.split_ok ? ffa_pkg::S_SH_RD : ffa_pkg::S_DONE;
         end
         ffa_pkg::S_SH_RD: begin
            state_in = sts.shift_more ? ffa_pkg::S_SH_WR : ffa_pkg::S_SP_LO;
         end
         ffa_pkg::S_SH_WR: state_in = ffa_pkg::S_SH_RD;
         ffa_pkg::S_SP_LO: state_in = ffa_pkg::S_SP_HI;
         ffa_pkg::S_SP_HI: state_in = ffa_pkg::S_DONE;
         ffa_pkg::S_F_RD: begin
            state_in = sts.idx_eq_count ? ffa_pkg::S_DONE : ffa_pkg::S_F_EV;
         end
         ffa_pkg::S_F_EV: begin
            state_in = sts.tp_hit ? ffa_pkg::S_F_HIT : ffa_pkg::S_F_RD;
         end
         ffa_pkg::S_F_HIT: begin
            if (!sts.l_last) state_in = ffa_pkg::S_F_NX;
            else if (sts.l_zero) state_in = ffa_pkg::S_DONE;
            else state_in = ffa_pkg::S_F_TAIL;
         end
         ffa_pkg::S_F_TAIL: state_in = ffa_pkg::S_DONE;
         ffa_pkg::S_F_NX: begin
            state_in = sts.rd_used ? ffa_pkg::S_F_PRV : ffa_pkg::S_GAP_RD;
         end
         ffa_pkg::S_GAP_RD: begin
            if (sts.gap_more) state_in = ffa_pkg::S_GAP_WR;
            else if (second_ff) state_in = ffa_pkg::S_DONE;
            else state_in = ffa_pkg::S_F_PRV;
         end
         ffa_pkg::S_GAP_WR: state_in = ffa_pkg::S_GAP_RD;
         ffa_pkg::S_F_PRV: begin
            state_in = sts.l_zero ? ffa_pkg::S_DONE : ffa_pkg::S_F_PM;
         end
         ffa_pkg::S_F_PM: begin
            if (sts.rd_used) begin
               state_in = ffa_pkg::S_DONE;
            end else begin
               state_in  = ffa_pkg::S_GAP_RD;
               second_in = 1'b1;
            end
         end
         ffa_pkg::S_DONE: begin
            if (sts.out_free) state_in = ffa_pkg::S_IDLE;
         end
         default: state_in = ffa_pkg::S_IDLE;
      endcase
   end

   // Commands for the datapath.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ffa_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ffa_pkg::S_DISPATCH: begin
            cmd.res_wr     = 1'b1;
            cmd.res_status = ffa_pkg::ST_OK;
            if (sts.action == ffa_pkg::ACT_CLEAR) cmd.cnt_op = ffa_pkg::CNT_ZERO;
         end
         ffa_pkg::S_A_CHK: begin
            if (sts.illegal) begin
               cmd.res_wr     = 1'b1;
               cmd.res_status = ffa_pkg::ST_ILLEGAL;
            end else if (sts.count_zero) begin
               cmd.wr_en    = 1'b1;
               cmd.wsel     = ffa_pkg::WA_IDX;
               cmd.wdat     = ffa_pkg::WD_FIRST;
               cmd.cnt_op   = ffa_pkg::CNT_ONE;
               cmd.res_wr   = 1'b1;
               cmd.addr_sel = ffa_pkg::ADDR_FIRST;
            end
         end
         ffa_pkg::S_A_RD: begin
            if (!sts.idx_eq_count) begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = ffa_pkg::RA_IDX;
            end else if (sts.count_full) begin
               cmd.res_wr     = 1'b1;
               cmd.res_status = ffa_pkg::ST_NO_ENTRY;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = ffa_pkg::RA_IDX_M1;
            end
         end
         ffa_pkg::S_A_EV: begin
            if (sts.fit) begin
               cmd.l_load = 1'b1;
               cmd.cur_op = ffa_pkg::CUR_LOAD;
            end else begin
               cmd.idx_op = ffa_pkg::IDX_INC;
            end
         end
         ffa_pkg::S_A_APP: begin
            cmd.res_wr = 1'b1;
            if (sts.space_bad) begin
               cmd.res_status = ffa_pkg::ST_NO_SPACE;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wsel     = ffa_pkg::WA_IDX;
               cmd.wdat     = ffa_pkg::WD_APPEND;
               cmd.cnt_op   = ffa_pkg::CNT_INC;
               cmd.addr_sel = ffa_pkg::ADDR_APPEND;
            end
         end
         ffa_pkg::S_A_HIT: begin
            if (sts.split_ok) begin
               cmd.idx_op = ffa_pkg::IDX_COUNT;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wsel     = ffa_pkg::WA_L;
               cmd.wdat     = ffa_pkg::WD_WHOLE;
               cmd.res_wr   = 1'b1;
               cmd.addr_sel = ffa_pkg::ADDR_WHOLE;
            end
         end
         ffa_pkg::S_SH_RD: begin
            if (sts.shift_more) begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = ffa_pkg::RA_IDX_M1;
            end
         end
         ffa_pkg::S_SH_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wsel   = ffa_pkg::WA_IDX;
            cmd.wdat   = ffa_pkg::WD_COPY;
            cmd.idx_op = ffa_pkg::IDX_DEC;
         end
         ffa_pkg::S_SP_LO: begin
            cmd.wr_en    = 1'b1;
            cmd.wsel     = ffa_pkg::WA_L;
            cmd.wdat     = ffa_pkg::WD_SPLIT_LO;
            cmd.res_wr   = 1'b1;
            cmd.addr_sel = ffa_pkg::ADDR_SPLIT;
         end
         ffa_pkg::S_SP_HI: begin
            cmd.wr_en  = 1'b1;
            cmd.wsel   = ffa_pkg::WA_L_P1;
            cmd.wdat   = ffa_pkg::WD_SPLIT_HI;
            cmd.cnt_op = ffa_pkg::CNT_INC;
         end
         ffa_pkg::S_F_RD: begin
            if (sts.idx_eq_count) begin
               cmd.res_wr     = 1'b1;
               cmd.res_status = ffa_pkg::ST_NOT_FOUND;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = ffa_pkg::RA_IDX;
            end
         end
         ffa_pkg::S_F_EV: begin
            cmd.tp_sub = 1'b1;
            if (sts.tp_hit) begin
               cmd.l_load = 1'b1;
               cmd.cur_op = ffa_pkg::CUR_LOAD;
            end else begin
               cmd.idx_op = ffa_pkg::IDX_INC;
            end
         end
         ffa_pkg::S_F_HIT: begin
            cmd.res_wr     = 1'b1;
            cmd.res_status = ffa_pkg::ST_OK;
            if (!sts.l_last) begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = ffa_pkg::RA_L_P1;
            end else if (sts.l_zero) begin
               cmd.cnt_op = ffa_pkg::CNT_ZERO;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = ffa_pkg::RA_L_M1;
            end
         end
         ffa_pkg::S_F_TAIL: begin
            cmd.cnt_op = sts.rd_used ? ffa_pkg::CNT_L : ffa_pkg::CNT_L_M1;
         end
         ffa_pkg::S_F_NX: begin
            cmd.wr_en = 1'b1;
            cmd.wsel  = ffa_pkg::WA_L;
            if (sts.rd_used) begin
               cmd.wdat = ffa_pkg::WD_FREE;
            end else begin
               cmd.wdat   = ffa_pkg::WD_NEXT_MERGE;
               cmd.cur_op = ffa_pkg::CUR_ADD;
               cmd.idx_op = ffa_pkg::IDX_L_P1;
            end
         end
         ffa_pkg::S_GAP_RD: begin
            if (sts.gap_more) begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = ffa_pkg::RA_IDX_P1;
            end else begin
               cmd.cnt_op = ffa_pkg::CNT_DEC;
            end
         end
         ffa_pkg::S_GAP_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wsel   = ffa_pkg::WA_IDX;
            cmd.wdat   = ffa_pkg::WD_COPY;
            cmd.idx_op = ffa_pkg::IDX_INC;
         end
         ffa_pkg::S_F_PRV: begin
            if (!sts.l_zero) begin
               cmd.rd_en = 1'b1;
               cmd.rsel  = ffa_pkg::RA_L_M1;
            end
         end
         ffa_pkg::S_F_PM: begin
            if (!sts.rd_used) begin
               cmd.wr_en  = 1'b1;
               cmd.wsel   = ffa_pkg::WA_L_M1;
               cmd.wdat   = ffa_pkg::WD_PREV_MERGE;
               cmd.idx_op = ffa_pkg::IDX_L;
            end
         end
         ffa_pkg::S_DONE: begin
            cmd.publish = sts.out_free;
         end
         default: ;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ffa_pkg::S_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

endmodule

@@ rtl/first_fit_block_table_allocator_core.sv @@
`timescale 1ns / 1ps
// First-fit pool allocator over an ordered table of TABLE_ENTRIES blocks that
// carve the pool downward from pool_base + pool_size. One request is handled
// at a time and gives exactly one response beat. The table lives in a memory
// with one read and one write port and registered read data. An allocate scans
// entries in order and may move entries to open a split slot; a free scans
// entries and moves entries to close the gap for each merge. The next request
// is accepted as soon as a finished response sits in the output register.
// Register writes are accepted at any time and belong between requests.
module first_fit_block_table_allocator_core #(
   parameter int TABLE_ENTRIES = ffa_pkg::TABLE_ENTRIES
) (
   input logic      clock,
   input logic      reset,
   ffa_req_if.sink  req_ch,
   ffa_rsp_if.source rsp_ch,
   ffa_csr_if.sink  csr_ch
);

   ffa_pkg::cmd_type cmd;
   ffa_pkg::sts_type sts;

   // Register writes are always taken.
   assign csr_ch.ready = 1'b1;

   ffa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ffa_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_ch.action),
      .req_size          (req_ch.req_size),
      .req_block_address (req_ch.block_address),
      .csr_fire          (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_status        (rsp_ch.status),
      .rsp_address       (rsp_ch.address),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

@@ rtl/ffa_checker.sv @@
`timescale 1ns / 1ps
module ffa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_address
);

   // A waiting response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_address))
      else $error("response changed while stalled");

   // A failed request never reports an address.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ffa_pkg::ST_OK) |-> rsp_address == '0)
      else $error("failure carries an address");

   // Only one request is in work at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // No response comes out of reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");

endmodule

bind first_fit_block_table_allocator_core ffa_checker u_ffa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_status  (rsp_ch.status),
   .rsp_address (rsp_ch.address)
);
